// File: rtl/urd_pkg.sv
// ----------------------------------------------------------------------------
// urd_pkg
// Shared types and constants for the uniform random double generator.
// ----------------------------------------------------------------------------
package urd_pkg;

    localparam int WordBits = 64;

    typedef logic [WordBits-1:0] word_t;
    typedef logic [1:0]          status_t;

    // Status codes of a result item
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_FAIL      = 2'd1;
    localparam status_t STATUS_UNDERFLOW = 2'd2;

    // Bit pattern of -1.0
    localparam word_t MINUS_ONE_BITS = 64'hBFF0_0000_0000_0000;

    // Seeking words after which the exponent is below the subnormal range
    localparam logic [4:0] ZERO_WORDS_LIMIT = 5'd17;

    // Biased exponent of 2^63: 1023 + 63
    localparam logic signed [12:0] EXP_BIAS_TOP = 13'sd1086;

endpackage

// File: rtl/urd_if.sv
// ----------------------------------------------------------------------------
// urd_in_if / urd_out_if
// Valid/ready channels for random words in and double results out.
// ----------------------------------------------------------------------------
interface urd_in_if;
    import urd_pkg::*;
    logic  valid;
    logic  ready;
    word_t random_word;
    logic  source_fail;

    modport source (output valid, output random_word, output source_fail, input ready);
    modport sink   (input valid, input random_word, input source_fail, output ready);
endinterface

interface urd_out_if;
    import urd_pkg::*;
    logic    valid;
    logic    ready;
    word_t   value_bits;
    status_t status;

    modport source (output valid, output value_bits, output status, input ready);
    modport sink   (input valid, input value_bits, input status, output ready);
endinterface

// File: rtl/uniform_random_double.sv
// ----------------------------------------------------------------------------
// uniform_random_double
// Turns a stream of 64-bit random words into doubles uniform in [0,1].
// ----------------------------------------------------------------------------
// Each word item is taken into an input register and processed from there
// into a result register, one item per cycle unless the output stalls, with
// no stall of its own. A result comes from one to seventeen words: leading
// all-zero words lower the exponent by 64 each, the first nonzero word is
// normalized and refilled from the top of the following word (no refill word
// when its top bit is set), and the seventeenth seeking word gives +0 with
// underflow status. A word flagged as a source failure gives -1.0 with failure
// status and restarts the search. The path that sets the clock is the refill
// shift followed by the 53-bit rounding add.
module uniform_random_double
    import urd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    urd_in_if.sink      in,
    urd_out_if.source   out
);

    // Input register
    logic  s1_valid_reg;
    word_t s1_word_reg;
    logic  s1_fail_reg;

    // Search state
    logic       phase_reg;
    logic [4:0] zeros_reg;
    word_t      held_reg;
    logic [5:0] lz_reg;

    // Result register
    logic    out_valid_reg;
    word_t   out_bits_reg;
    status_t out_status_reg;

    logic fire;
    assign fire     = s1_valid_reg && (!out_valid_reg || out.ready);
    assign in.ready = !s1_valid_reg || fire;

    // Count leading zeros of the first nonzero word
    function automatic logic [5:0] clz64(word_t w);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < WordBits; i++)
        begin
            if (w[i])
                n = 6'(WordBits - 1 - i);
        end
        return n;
    endfunction

    logic       [4:0]  z_inc;
    logic              underflow;
    logic              word_zero;
    logic       [5:0]  word_lz;
    logic       [4:0]  zsel;
    logic       [5:0]  ssel;
    logic       [127:0] cat_shift;
    word_t             sig;
    logic              inc11;
    logic       [53:0] m54;
    logic       [52:0] m53;
    logic              carry;
    logic signed [12:0] biased;
    logic       [52:0] sub_q;
    logic              sub_inc;
    word_t             dbl_bits;

    // Pick significand and exponent source, then round to 53 bits
    always_comb
    begin
        z_inc     = zeros_reg + 5'd1;
        underflow = (z_inc >= ZERO_WORDS_LIMIT);
        word_zero = (s1_word_reg == '0);
        word_lz   = clz64(s1_word_reg);
        zsel      = phase_reg ? zeros_reg : z_inc;
        ssel      = phase_reg ? lz_reg : 6'd0;
        cat_shift = {held_reg, s1_word_reg} << lz_reg;
        sig       = (phase_reg ? cat_shift[127:64] : s1_word_reg) | 64'd1;

        inc11 = sig[10] && ((sig[9:0] != '0) || sig[11]);
        m54   = {1'b0, sig[63:11]} + {53'd0, inc11};
        carry = m54[53];
        m53   = carry ? m54[53:1] : m54[52:0];

        biased = EXP_BIAS_TOP - $signed({2'b0, zsel, 6'b0}) - $signed({7'b0, ssel})
                 + $signed({12'b0, carry});

        // Second rounding into subnormals: shift right by one or two
        if (biased == 13'sd0)
        begin
            sub_q   = m53 >> 1;
            sub_inc = m53[0] && m53[1];
        end
        else
        begin
            sub_q   = m53 >> 2;
            sub_inc = m53[1] && (m53[0] || m53[2]);
        end

        if (biased > 13'sd0)
            dbl_bits = {1'b0, biased[10:0], m53[51:0]};
        else
            dbl_bits = {11'd0, sub_q + {52'd0, sub_inc}};
    end

    // Hold input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in.ready)
            s1_valid_reg <= in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in.ready && in.valid)
        begin
            s1_word_reg <= in.random_word;
            s1_fail_reg <= in.source_fail;
        end
    end

    // Advance search state and load result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 1'b0;
            zeros_reg      <= 5'd0;
            held_reg       <= '0;
            lz_reg         <= 6'd0;
            out_valid_reg  <= 1'b0;
            out_bits_reg   <= '0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            if (out.ready && !fire)
                out_valid_reg <= 1'b0;
            if (fire)
            begin
                priority if (s1_fail_reg)
                begin
                    phase_reg      <= 1'b0;
                    zeros_reg      <= 5'd0;
                    lz_reg         <= 6'd0;
                    out_valid_reg  <= 1'b1;
                    out_bits_reg   <= MINUS_ONE_BITS;
                    out_status_reg <= STATUS_FAIL;
                end
                else if (phase_reg)
                begin
                    phase_reg      <= 1'b0;
                    zeros_reg      <= 5'd0;
                    lz_reg         <= 6'd0;
                    out_valid_reg  <= 1'b1;
                    out_bits_reg   <= dbl_bits;
                    out_status_reg <= STATUS_OK;
                end
                else if (underflow)
                begin
                    zeros_reg      <= 5'd0;
                    out_valid_reg  <= 1'b1;
                    out_bits_reg   <= '0;
                    out_status_reg <= STATUS_UNDERFLOW;
                end
                else if (word_zero)
                begin
                    zeros_reg     <= z_inc;
                    out_valid_reg <= 1'b0;
                end
                else if (word_lz == 6'd0)
                begin
                    zeros_reg      <= 5'd0;
                    out_valid_reg  <= 1'b1;
                    out_bits_reg   <= dbl_bits;
                    out_status_reg <= STATUS_OK;
                end
                else
                begin
                    zeros_reg     <= z_inc;
                    held_reg      <= s1_word_reg;
                    lz_reg        <= word_lz;
                    phase_reg     <= 1'b1;
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign out.valid      = out_valid_reg;
    assign out.value_bits = out_bits_reg;
    assign out.status     = out_status_reg;

    // Seeking count never passes the underflow limit
    assert property (@(posedge clk) disable iff (!rst_n)
        zeros_reg < ZERO_WORDS_LIMIT)
        else $error("zero word count out of range");

    // Refill phase always has a nonzero shift
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (lz_reg != 6'd0))
        else $error("refill phase without leading zeros");

    // Good results are non-negative with an exponent no greater than that of 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STATUS_OK) |->
            (!out_bits_reg[63] && out_bits_reg[62:52] <= 11'd1023))
        else $error("result outside unit interval");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out.ready) |=> (out_valid_reg && $stable(out_bits_reg)))
        else $error("stalled result changed");

endmodule

// File: dv/uniform_random_double_tb.sv
// ----------------------------------------------------------------------------
// uniform_random_double_tb
// Drives random word items into the double generator and checks every result
// against a cycle-free model of the conversion: zero words, refill, sticky
// bit, two roundings, underflow after seventeen words and source failure.
// ----------------------------------------------------------------------------
module uniform_random_double_tb;
    import urd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        word_t   value_bits;
        status_t status;
    } double_item_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   send_idle_pct;
    int   recv_idle_pct;

    // Model state
    logic       mdl_refill;
    logic [4:0] mdl_zero_words;
    word_t      mdl_held;
    logic [5:0] mdl_lead;

    double_item_t expected_doubles[$];

    urd_in_if  in_ch ();
    urd_out_if out_ch ();

    uniform_random_double DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Round m right by k bits, ties to even
    function automatic word_t round_shift(word_t m, int k);
        word_t q;
        word_t rem;
        word_t half;
        q    = m >> k;
        rem  = m & ((64'd1 << k) - 64'd1);
        half = 64'd1 << (k - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        return q;
    endfunction

    // Pack sig * 2^exp into double bits, sig normalized
    function automatic word_t pack_double(word_t sig, int exp);
        word_t m;
        int    e;
        int    k;
        m = round_shift(sig, 11);
        e = exp + 63;
        if (m[53])
        begin
            m = m >> 1;
            e++;
        end
        if (e >= -1022)
            return (word_t'(e + 1023) << 52) | (m & 64'h000F_FFFF_FFFF_FFFF);
        k = -1022 - e;
        if (k > 60)
            return '0;
        return round_shift(m, k);
    endfunction

    function automatic int count_lz(word_t w);
        int n;
        n = 0;
        if (w == '0)
            return 64;
        while (!w[63])
        begin
            w = w << 1;
            n++;
        end
        return n;
    endfunction

    task automatic clear_model();
        mdl_refill     = 1'b0;
        mdl_zero_words = '0;
        mdl_held       = '0;
        mdl_lead       = '0;
    endtask

    // Advance the model by one accepted word item
    task automatic predict_word(word_t w, logic fail);
        double_item_t r;
        int           exp;
        int           s;
        word_t        sig;
        if (fail)
        begin
            clear_model();
            r.value_bits = MINUS_ONE_BITS;
            r.status     = STATUS_FAIL;
            expected_doubles.push_back(r);
            return;
        end
        if (!mdl_refill)
        begin
            mdl_zero_words = mdl_zero_words + 5'd1;
            exp = -64 * int'(mdl_zero_words);
            if (exp < -1074)
            begin
                clear_model();
                r.value_bits = '0;
                r.status     = STATUS_UNDERFLOW;
                expected_doubles.push_back(r);
                return;
            end
            if (w == '0)
                return;
            if (w[63])
            begin
                clear_model();
                r.value_bits = pack_double(w | 64'd1, exp);
                r.status     = STATUS_OK;
                expected_doubles.push_back(r);
                return;
            end
            mdl_held   = w;
            mdl_lead   = 6'(count_lz(w));
            mdl_refill = 1'b1;
            return;
        end
        s   = int'(mdl_lead);
        sig = mdl_held;
        exp = -64 * int'(mdl_zero_words) - s;
        if (s != 0)
            sig = (sig << s) | (w >> (64 - s));
        sig = sig | 64'd1;
        clear_model();
        r.value_bits = pack_double(sig, exp);
        r.status     = STATUS_OK;
        expected_doubles.push_back(r);
    endtask

    task automatic report_mismatch(string what, word_t got, word_t want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Send one word item; inputs change on the falling edge
    task automatic send_word(word_t w, logic fail);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.random_word <= w;
        in_ch.source_fail <= fail;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_word(w, fail);
        @(negedge clk);
    endtask

    // Receiver stalls
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Check each accepted result
    always @(posedge clk)
    begin
        double_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_doubles.size() == 0)
            begin
                report_mismatch("unexpected item", out_ch.value_bits, '0);
            end
            else
            begin
                want = expected_doubles.pop_front();
                if (out_ch.value_bits !== want.value_bits)
                    report_mismatch("value_bits", out_ch.value_bits, want.value_bits);
                if (out_ch.status !== want.status)
                    report_mismatch("status", word_t'(out_ch.status), word_t'(want.status));
            end
        end
    end

    function automatic word_t rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Word with a chosen leading-zero count
    function automatic word_t word_with_lz(int lz);
        word_t w;
        w = rand_word() | 64'h8000_0000_0000_0000;
        return w >> lz;
    endfunction

    task automatic test_directed();
        int i;
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'h8000_0000_0000_0000, 1'b0);
        send_word(64'h8000_0000_0000_0400, 1'b0);
        send_word(64'h8000_0000_0000_0C00, 1'b0);
        send_word(64'h0000_0000_0000_0001, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'h4000_0000_0000_0000, 1'b0);
        send_word(64'h0000_0000_0000_0000, 1'b0);
        // Fifteen zero words then a set top bit: lowest exponent without refill
        for (i = 0; i < 15; i++)
            send_word('0, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        // Fifteen zero words then a deep refill: subnormal results
        for (i = 0; i < 15; i++)
            send_word('0, 1'b0);
        send_word(64'h0000_0000_0000_0001, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        for (i = 0; i < 15; i++)
            send_word('0, 1'b0);
        send_word(64'h0000_0000_0000_0003, 1'b0);
        send_word(64'h0000_0000_0000_0000, 1'b0);
        // Failure while seeking and while waiting for the refill
        send_word(64'h0000_0000_0000_0000, 1'b1);
        send_word(64'h0000_0000_0000_0010, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    endtask

    task automatic test_underflow();
        int i;
        for (i = 0; i < 16; i++)
            send_word('0, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    endtask

    // Mostly well-formed sequences with random depth, plus noise
    task automatic test_random(int count);
        int n;
        int z;
        int i;
        n = 0;
        while (n < count)
        begin
            case ($urandom_range(9))
                0: begin send_word(rand_word(), 1'($urandom_range(1))); n++; end
                1: begin send_word(rand_word(), 1'b1); n++; end
                default:
                begin
                    z = ($urandom_range(7) == 0) ? $urandom_range(17) : $urandom_range(2);
                    for (i = 0; i < z; i++)
                        send_word('0, 1'b0);
                    send_word(word_with_lz($urandom_range(63)), 1'b0);
                    send_word(rand_word(), ($urandom_range(40) == 0));
                    n += z + 2;
                end
            endcase
        end
    endtask

    initial
    begin
        errors            = 0;
        send_idle_pct     = 11;
        recv_idle_pct     = 82;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.random_word = '0;
        in_ch.source_fail = 1'b0;
        out_ch.ready      = 1'b0;
        clear_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_underflow();
        test_random(370);
        send_idle_pct = 82;
        recv_idle_pct = 11;
        test_random(370);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(370);
        in_ch.valid <= 1'b0;
        while (expected_doubles.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_doubles.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/urd_pkg.sv
rtl/urd_if.sv
rtl/uniform_random_double.sv
dv/uniform_random_double_tb.sv
